/* sv/ssed_pkg.sv */
// Shared constants, types and helpers for the scale-space extremum detector.
package ssed_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
    localparam int SAMPLE_BITS = 24;
    localparam int COORD_BITS  = 10;
    localparam int CFG_BITS    = 11;
    localparam int SIGMA_BITS  = 4;
    localparam int IDX_BITS    = 2;
    localparam int LEVELS      = 3;
    localparam int ROWS        = 3;
    localparam int LANES       = 3;
    localparam int CNT_BITS    = (ADDR_BITS + 1 > CFG_BITS) ? ADDR_BITS + 1 : CFG_BITS;

    localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_SCALE_SIGMA  = 2'd2;

    localparam logic [CFG_BITS-1:0]   WIDTH_RESET  = 11'd640;
    localparam logic [CFG_BITS-1:0]   HEIGHT_RESET = 11'd480;
    localparam logic [SIGMA_BITS-1:0] SIGMA_RESET  = 4'd3;

    localparam logic [CNT_BITS-1:0]   WIDTH_MIN  = CNT_BITS'(3);
    localparam logic [CNT_BITS-1:0]   WIDTH_MAX  = CNT_BITS'(MAX_WIDTH);
    localparam logic [CNT_BITS-1:0]   HEIGHT_MIN = CNT_BITS'(3);
    localparam logic [CNT_BITS-1:0]   HEIGHT_MAX = CNT_BITS'(1024);
    localparam logic [SIGMA_BITS-1:0] SIGMA_MIN  = 4'd2;
    localparam logic [SIGMA_BITS-1:0] SIGMA_MAX  = 4'd15;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [LEVELS-1:0]   triple_t;
    typedef triple_t [ROWS-1:0]     column_t;

    typedef struct packed {
        logic ge;
        logic lt;
    } lane_res_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  x;
        logic [COORD_BITS-1:0] y;
        logic                  test;
        sample_t               center;
    } pix_tag_t;

    function automatic logic [CNT_BITS-1:0] clamp_cnt(
        input logic [CNT_BITS-1:0] v,
        input logic [CNT_BITS-1:0] lo,
        input logic [CNT_BITS-1:0] hi
    );
        logic [CNT_BITS-1:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    function automatic logic [SIGMA_BITS-1:0] clamp_sigma(input logic [SIGMA_BITS-1:0] v);
        logic [SIGMA_BITS-1:0] r;
        r = v;
        if (v < SIGMA_MIN)
        begin
            r = SIGMA_MIN;
        end
        else if (v > SIGMA_MAX)
        begin
            r = SIGMA_MAX;
        end
        return r;
    endfunction

endpackage

/* sv/ssed_row_store.sv */
// Two line buffers holding the previous two rows of all three levels.
module ssed_row_store (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [ssed_pkg::ADDR_BITS-1:0] rd_addr,
    output ssed_pkg::triple_t             rd_older,
    output ssed_pkg::triple_t             rd_newer,
    input  logic                          wr_en,
    input  logic [ssed_pkg::ADDR_BITS-1:0] wr_addr,
    input  ssed_pkg::triple_t             wr_older,
    input  ssed_pkg::triple_t             wr_newer
);

    ssed_pkg::triple_t older_mem [ssed_pkg::MAX_WIDTH];
    ssed_pkg::triple_t newer_mem [ssed_pkg::MAX_WIDTH];
    ssed_pkg::triple_t rd_older_reg;
    ssed_pkg::triple_t rd_newer_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
    end

    // Hold read data until the next read so a stalled pixel keeps its column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_older_reg <= older_mem[rd_addr];
            rd_newer_reg <= newer_mem[rd_addr];
        end
    end

    assign rd_older = rd_older_reg;
    assign rd_newer = rd_newer_reg;

endmodule

/* sv/ssed_lane.sv */
// One comparison lane: tests the center sample against a 3x3 column of neighbors.
module ssed_lane (
    input  ssed_pkg::sample_t   center,
    input  ssed_pkg::column_t   column,
    input  logic                skip_center,
    output ssed_pkg::lane_res_t res
);

    always_comb
    begin
        res.ge = 1'b1;
        res.lt = 1'b1;
        for (int r = 0; r < ssed_pkg::ROWS; r++)
        begin
            for (int l = 0; l < ssed_pkg::LEVELS; l++)
            begin
                // drop the center sample itself from its own lane
                if (!(skip_center && r == 1 && l == 1))
                begin
                    if (!($signed(center) >= $signed(column[r][l])))
                    begin
                        res.ge = 1'b0;
                    end
                    if (!($signed(center) < $signed(column[r][l])))
                    begin
                        res.lt = 1'b0;
                    end
                end
            end
        end
    end

endmodule

/* sv/ssed_merge.sv */
// Lane result register, merge of lane flags and the blob output register.
module ssed_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  ssed_pkg::lane_res_t [ssed_pkg::LANES-1:0] lanes,
    input  ssed_pkg::pix_tag_t                     tag,
    input  logic [ssed_pkg::SIGMA_BITS-1:0]        sigma,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [ssed_pkg::COORD_BITS-1:0]        blob_x,
    output logic [ssed_pkg::COORD_BITS-1:0]        blob_y,
    output logic signed [ssed_pkg::SAMPLE_BITS-1:0] blob_value,
    output logic                                   is_maximum,
    output logic [ssed_pkg::SIGMA_BITS-1:0]        blob_scale
);

    logic                                     s2_valid_reg;
    ssed_pkg::lane_res_t [ssed_pkg::LANES-1:0] s2_lanes_reg;
    ssed_pkg::pix_tag_t                       s2_tag_reg;
    logic                                     out_valid_reg;
    logic [ssed_pkg::COORD_BITS-1:0]          blob_x_reg;
    logic [ssed_pkg::COORD_BITS-1:0]          blob_y_reg;
    ssed_pkg::sample_t                        blob_value_reg;
    logic                                     is_maximum_reg;
    logic [ssed_pkg::SIGMA_BITS-1:0]          blob_scale_reg;

    logic out_free;
    logic ge_all;
    logic lt_all;
    logic hit;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !s2_valid_reg || out_free;

    always_comb
    begin
        ge_all = 1'b1;
        lt_all = 1'b1;
        for (int i = 0; i < ssed_pkg::LANES; i++)
        begin
            ge_all = ge_all & s2_lanes_reg[i].ge;
            lt_all = lt_all & s2_lanes_reg[i].lt;
        end
    end

    assign hit = s2_valid_reg && s2_tag_reg.test && (ge_all || lt_all);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s2_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s2_lanes_reg <= lanes;
            s2_tag_reg   <= tag;
        end
        if (out_free && hit)
        begin
            blob_x_reg     <= ssed_pkg::COORD_BITS'(s2_tag_reg.x - ssed_pkg::ADDR_BITS'(1));
            blob_y_reg     <= s2_tag_reg.y - ssed_pkg::COORD_BITS'(1);
            blob_value_reg <= s2_tag_reg.center;
            is_maximum_reg <= ge_all;
            blob_scale_reg <= sigma;
        end
    end

    assign out_valid  = out_valid_reg;
    assign blob_x     = blob_x_reg;
    assign blob_y     = blob_y_reg;
    assign blob_value = blob_value_reg;
    assign is_maximum = is_maximum_reg;
    assign blob_scale = blob_scale_reg;

endmodule

/* sv/scale_space_extremum_detect_core.sv */
// A pixel's result goes from the edge that accepts it (row-store read at that edge)
// through one lane compare stage and one merge stage into the output register;
// an output stall holds it back. Throughput: one pixel per cycle without output stall,
// set by the row stores' one read and one write per cycle.
// Reset (rst_n, async, active low): position counters, window and valid bits clear,
// registers return to 640/480/3; row stores are not cleared and need no clearing pass.
module scale_space_extremum_detect_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [ssed_pkg::IDX_BITS-1:0]          cfg_index,
    input  logic [ssed_pkg::CFG_BITS-1:0]          cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ssed_pkg::SAMPLE_BITS-1:0] lower_level,
    input  logic signed [ssed_pkg::SAMPLE_BITS-1:0] middle_level,
    input  logic signed [ssed_pkg::SAMPLE_BITS-1:0] upper_level,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [ssed_pkg::COORD_BITS-1:0]        blob_x,
    output logic [ssed_pkg::COORD_BITS-1:0]        blob_y,
    output logic signed [ssed_pkg::SAMPLE_BITS-1:0] blob_value,
    output logic                                   is_maximum,
    output logic [ssed_pkg::SIGMA_BITS-1:0]        blob_scale
);

    logic [ssed_pkg::CFG_BITS-1:0]   frame_width_reg;
    logic [ssed_pkg::CFG_BITS-1:0]   frame_height_reg;
    logic [ssed_pkg::SIGMA_BITS-1:0] scale_sigma_reg;

    logic [ssed_pkg::ADDR_BITS-1:0]  col_count_reg;
    logic [ssed_pkg::ADDR_BITS-1:0]  col_count_next;
    logic [ssed_pkg::COORD_BITS-1:0] row_count_reg;
    logic [ssed_pkg::COORD_BITS-1:0] row_count_next;

    logic                            s1_valid_reg;
    ssed_pkg::triple_t               s1_cur_reg;
    logic [ssed_pkg::ADDR_BITS-1:0]  s1_x_reg;
    logic [ssed_pkg::COORD_BITS-1:0] s1_y_reg;

    ssed_pkg::column_t [1:0]         win_reg;

    logic [ssed_pkg::CNT_BITS-1:0]   width_eff;
    logic [ssed_pkg::CNT_BITS-1:0]   height_eff;
    logic [ssed_pkg::SIGMA_BITS-1:0] sigma_eff;

    logic                            accept;
    logic                            s1_fire;
    logic                            s2_ready;
    ssed_pkg::triple_t               rd_older;
    ssed_pkg::triple_t               rd_newer;
    ssed_pkg::column_t               col_new;
    ssed_pkg::column_t [ssed_pkg::LANES-1:0]   lane_cols;
    ssed_pkg::lane_res_t [ssed_pkg::LANES-1:0] lane_res;
    ssed_pkg::pix_tag_t              tag;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= ssed_pkg::WIDTH_RESET;
            frame_height_reg <= ssed_pkg::HEIGHT_RESET;
            scale_sigma_reg  <= ssed_pkg::SIGMA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssed_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                ssed_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                ssed_pkg::REG_SCALE_SIGMA:
                    scale_sigma_reg <= cfg_wdata[ssed_pkg::SIGMA_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign width_eff  = ssed_pkg::clamp_cnt(ssed_pkg::CNT_BITS'(frame_width_reg),
                                            ssed_pkg::WIDTH_MIN, ssed_pkg::WIDTH_MAX);
    assign height_eff = ssed_pkg::clamp_cnt(ssed_pkg::CNT_BITS'(frame_height_reg),
                                            ssed_pkg::HEIGHT_MIN, ssed_pkg::HEIGHT_MAX);
    assign sigma_eff  = ssed_pkg::clamp_sigma(scale_sigma_reg);

    // handshake
    assign s1_fire  = s1_valid_reg && s2_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign accept   = in_valid && in_ready;

    // raster position, wrapping at the effective frame size
    always_comb
    begin
        col_count_next = col_count_reg + ssed_pkg::ADDR_BITS'(1);
        row_count_next = row_count_reg;
        if (ssed_pkg::CNT_BITS'(col_count_reg) + ssed_pkg::CNT_BITS'(1) >= width_eff)
        begin
            col_count_next = '0;
            if (ssed_pkg::CNT_BITS'(row_count_reg) + ssed_pkg::CNT_BITS'(1) >= height_eff)
            begin
                row_count_next = '0;
            end
            else
            begin
                row_count_next = row_count_reg + ssed_pkg::COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            // advance the window one column per pixel
            if (s1_fire)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= col_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg[0] <= lower_level;
            s1_cur_reg[1] <= middle_level;
            s1_cur_reg[2] <= upper_level;
            s1_x_reg      <= col_count_reg;
            s1_y_reg      <= row_count_reg;
        end
    end

    ssed_row_store u_row_store (
        .clk      (clk),
        .rd_en    (accept),
        .rd_addr  (col_count_reg),
        .rd_older (rd_older),
        .rd_newer (rd_newer),
        .wr_en    (s1_fire),
        .wr_addr  (s1_x_reg),
        .wr_older (rd_newer),
        .wr_newer (s1_cur_reg)
    );

    assign col_new[0] = rd_older;
    assign col_new[1] = rd_newer;
    assign col_new[2] = s1_cur_reg;

    assign lane_cols[0] = win_reg[0];
    assign lane_cols[1] = win_reg[1];
    assign lane_cols[2] = col_new;

    for (genvar g = 0; g < ssed_pkg::LANES; g++)
    begin : g_lane
        ssed_lane u_lane (
            .center      (win_reg[1][1][1]),
            .column      (lane_cols[g]),
            .skip_center (1'(g == 1)),
            .res         (lane_res[g])
        );
    end

    assign tag.x      = s1_x_reg;
    assign tag.y      = s1_y_reg;
    assign tag.test   = (s1_x_reg >= ssed_pkg::ADDR_BITS'(2))
                        && (s1_y_reg >= ssed_pkg::COORD_BITS'(2));
    assign tag.center = win_reg[1][1][1];

    ssed_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_fire),
        .in_ready   (s2_ready),
        .lanes      (lane_res),
        .tag        (tag),
        .sigma      (sigma_eff),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .blob_x     (blob_x),
        .blob_y     (blob_y),
        .blob_value (blob_value),
        .is_maximum (is_maximum),
        .blob_scale (blob_scale)
    );

endmodule

/* sv/ssed_checker.sv */
// Port-level checks for the extremum detector and their binding to the top level.
module ssed_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_ready,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic [ssed_pkg::COORD_BITS-1:0]        blob_x,
    input logic [ssed_pkg::COORD_BITS-1:0]        blob_y,
    input logic signed [ssed_pkg::SAMPLE_BITS-1:0] blob_value,
    input logic                                   is_maximum,
    input logic [ssed_pkg::SIGMA_BITS-1:0]        blob_scale
);

    // input side may only stall when the output register is full and stalled
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    // a stalled blob keeps its transaction payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(blob_x) && $stable(blob_y)
            && $stable(blob_value) && $stable(is_maximum) && $stable(blob_scale)))
        else $error("output transaction changed while stalled");

    // border pixels are never tested
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (blob_x != '0 && blob_y != '0))
        else $error("blob reported on the frame border");

    a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (blob_scale >= ssed_pkg::SIGMA_MIN && blob_scale <= ssed_pkg::SIGMA_MAX))
        else $error("blob scale out of range");

endmodule

bind scale_space_extremum_detect_core ssed_checker u_ssed_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .blob_x     (blob_x),
    .blob_y     (blob_y),
    .blob_value (blob_value),
    .is_maximum (is_maximum),
    .blob_scale (blob_scale)
);
